[rtl/bsda_pkg.sv]
// ----------------------------------------------------------------------------
// bsda_pkg: shared definitions for the signed decimal ALU
// Digit count, operation codes and the structures passed between the
// digit lanes, the carry merge units and the top level.
// ----------------------------------------------------------------------------
package bsda_pkg;

	// Number of decimal digits in one operand.
	localparam int DIGITS  = 16;
	// Bits of the packed BCD magnitude actually used.
	localparam int MAG_W   = 4 * DIGITS;
	// Width of the digit ports.
	localparam int FIELD_W = 64;

	// Operation codes.
	localparam logic [1:0] OP_ADD   = 2'd0;
	localparam logic [1:0] OP_NEG   = 2'd1;
	localparam logic [1:0] OP_MUL10 = 2'd2;
	localparam logic [1:0] OP_DIV10 = 2'd3;

	typedef logic [3:0] digit_t;

	// Raw sum of two digits with its carry generate and propagate terms.
	typedef struct packed {
		logic [4:0] sum;
		logic       gen;
		logic       prop;
	} dsum_t;

	// Everything one digit lane produces.
	typedef struct packed {
		digit_t a_digit;
		dsum_t  add;
		dsum_t  amb;
		dsum_t  bma;
	} lane_t;

	// A finished decimal sum over all digits.
	typedef struct packed {
		logic             cout;
		logic [MAG_W-1:0] digits;
	} adder_t;

endpackage

[rtl/bsda_lane.sv]
// ----------------------------------------------------------------------------
// bsda_lane: one decimal digit lane
// Clamps both input digits to nine and forms the raw digit sums for a+b,
// a plus the nine's complement of b, and b plus the nine's complement of a.
// ----------------------------------------------------------------------------
module bsda_lane
	import bsda_pkg::*;
(
	input  logic [3:0] a_nib,
	input  logic [3:0] b_nib,
	output lane_t      lane
);

	digit_t a_c;
	digit_t b_c;

	// A nibble above nine reads as nine.
	function automatic digit_t clamp_digit(input logic [3:0] d);
		return (d > 4'd9) ? 4'd9 : d;
	endfunction

	// Digit sum with its lookahead terms.
	function automatic dsum_t make_sum(input digit_t x, input digit_t y);
		dsum_t s;
		s.sum  = {1'b0, x} + {1'b0, y};
		s.gen  = (s.sum >= 5'd10);
		s.prop = (s.sum == 5'd9);
		return s;
	endfunction

	assign a_c = clamp_digit(a_nib);
	assign b_c = clamp_digit(b_nib);

	// The three digit sums the adders need.
	always_comb begin
		lane.a_digit = a_c;
		lane.add     = make_sum(a_c, b_c);
		lane.amb     = make_sum(a_c, 4'd9 - b_c);
		lane.bma     = make_sum(b_c, 4'd9 - a_c);
	end

endmodule

[rtl/bsda_merge.sv]
// ----------------------------------------------------------------------------
// bsda_merge: decimal carry merge
// Resolves the digit carries of one decimal adder with a parallel prefix
// network over the lane terms and corrects each digit sum to a BCD digit.
// ----------------------------------------------------------------------------
module bsda_merge
	import bsda_pkg::*;
(
	input  dsum_t [DIGITS-1:0] sums,
	input  logic               cin,
	output adder_t             result
);

	localparam int LEVELS = (DIGITS > 1) ? $clog2(DIGITS) : 1;

	logic [DIGITS-1:0] gl [LEVELS+1];
	logic [DIGITS-1:0] pl [LEVELS+1];
	logic [DIGITS:0]   carry;

	// Group generate and propagate over digit i down to digit 0.
	always_comb begin
		for (int i = 0; i < DIGITS; i++) begin
			gl[0][i] = sums[i].gen;
			pl[0][i] = sums[i].prop;
		end
		for (int l = 0; l < LEVELS; l++) begin
			for (int i = 0; i < DIGITS; i++) begin
				if (i >= (1 << l)) begin
					gl[l+1][i] = gl[l][i] | (pl[l][i] & gl[l][i-(1<<l)]);
					pl[l+1][i] = pl[l][i] & pl[l][i-(1<<l)];
				end else begin
					gl[l+1][i] = gl[l][i];
					pl[l+1][i] = pl[l][i];
				end
			end
		end
	end

	// Carry into each digit, then the decimal correction.
	always_comb begin
		logic [4:0] total;
		carry[0] = cin;
		for (int i = 0; i < DIGITS; i++) begin
			carry[i+1] = gl[LEVELS][i] | (pl[LEVELS][i] & cin);
		end
		for (int i = 0; i < DIGITS; i++) begin
			total = sums[i].sum + {4'd0, carry[i]};
			if (total >= 5'd10) begin
				total = total - 5'd10;
			end
			result.digits[4*i +: 4] = total[3:0];
		end
		result.cout = carry[DIGITS];
	end

endmodule

[rtl/bcd_signed_decimal_alu.sv]
// ----------------------------------------------------------------------------
// bcd_signed_decimal_alu: signed decimal ALU on sign-magnitude packed BCD
//
// A word is offered on op, a_negative, a_digits, b_negative and b_digits
// and taken at the rising edge where start is high and busy is low. busy
// is always low, so a new word can be taken at every clock edge.
// Operations: add a+b, negate a, multiply a by ten, divide a by ten.
// Each accepted word yields exactly one result word, shown on
// result_negative, result_digits and overflow for one cycle while done is
// high. A word passes through three pipeline stages: one digit lane stage,
// one carry merge stage and one select stage, so the throughput is one
// word per cycle.
// The carry merge stage holds three lookahead adders side by side (a+b,
// a-b and b-a) so that an add of either sign passes through the same stages.
// The receiver cannot stall; it must take each result as it is shown.
// Reset clears the pipeline valid bits; no result appears afterward until
// a new word is taken.
// ----------------------------------------------------------------------------
module bcd_signed_decimal_alu
	import bsda_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         op,
	input  logic               a_negative,
	input  logic [FIELD_W-1:0] a_digits,
	input  logic               b_negative,
	input  logic [FIELD_W-1:0] b_digits,
	output logic               done,
	output logic               result_negative,
	output logic [FIELD_W-1:0] result_digits,
	output logic               overflow
);

	lane_t [DIGITS-1:0] lane_c;

	logic               valid_s1;
	logic [1:0]         op_s1;
	logic               an_s1;
	logic               bn_s1;
	lane_t [DIGITS-1:0] lane_s1;

	dsum_t [DIGITS-1:0] add_sums;
	dsum_t [DIGITS-1:0] amb_sums;
	dsum_t [DIGITS-1:0] bma_sums;
	logic [MAG_W-1:0]   a_mag_c;
	adder_t             add_c;
	adder_t             amb_c;
	adder_t             bma_c;

	logic               valid_s2;
	logic [1:0]         op_s2;
	logic               an_s2;
	logic               bn_s2;
	logic [MAG_W-1:0]   a_mag_s2;
	adder_t             add_s2;
	adder_t             amb_s2;
	adder_t             bma_s2;

	logic               neg_c;
	logic [MAG_W-1:0]   mag_c;
	logic               ovf_c;

	// The pipeline never refuses a word.
	assign busy = 1'b0;

	// Digit lanes.
	for (genvar i = 0; i < DIGITS; i++) begin : g_lane
		bsda_lane u_lane (
			.a_nib (a_digits[4*i +: 4]),
			.b_nib (b_digits[4*i +: 4]),
			.lane  (lane_c[i])
		);
	end

	// Stage 1: lane results.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		op_s1   <= op;
		an_s1   <= a_negative;
		bn_s1   <= b_negative;
		lane_s1 <= lane_c;
	end

	// Gather the lane terms for the three adders.
	always_comb begin
		for (int i = 0; i < DIGITS; i++) begin
			add_sums[i]         = lane_s1[i].add;
			amb_sums[i]         = lane_s1[i].amb;
			bma_sums[i]         = lane_s1[i].bma;
			a_mag_c[4*i +: 4]   = lane_s1[i].a_digit;
		end
	end

	bsda_merge u_merge_add (
		.sums   (add_sums),
		.cin    (1'b0),
		.result (add_c)
	);

	bsda_merge u_merge_amb (
		.sums   (amb_sums),
		.cin    (1'b1),
		.result (amb_c)
	);

	bsda_merge u_merge_bma (
		.sums   (bma_sums),
		.cin    (1'b1),
		.result (bma_c)
	);

	// Stage 2: resolved sums.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		op_s2    <= op_s1;
		an_s2    <= an_s1;
		bn_s2    <= bn_s1;
		a_mag_s2 <= a_mag_c;
		add_s2   <= add_c;
		amb_s2   <= amb_c;
		bma_s2   <= bma_c;
	end

	// Select the result by operation. A carry out of a-b means a >= b.
	always_comb begin
		neg_c = an_s2;
		mag_c = a_mag_s2;
		ovf_c = 1'b0;
		unique case (op_s2)
			OP_ADD: begin
				if (an_s2 == bn_s2) begin
					mag_c = add_s2.digits;
					ovf_c = add_s2.cout;
				end else if (amb_s2.cout) begin
					mag_c = amb_s2.digits;
				end else begin
					mag_c = bma_s2.digits;
					neg_c = bn_s2;
				end
			end
			OP_NEG: begin
				neg_c = ~an_s2;
			end
			OP_MUL10: begin
				ovf_c = (a_mag_s2[MAG_W-1 -: 4] != 4'd0);
				mag_c = a_mag_s2 << 4;
			end
			OP_DIV10: begin
				mag_c = a_mag_s2 >> 4;
			end
			default: begin
				mag_c = a_mag_s2;
			end
		endcase
		// Zero is always positive.
		if (mag_c == '0) begin
			neg_c = 1'b0;
		end
	end

	// Stage 3: result word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		result_negative <= neg_c;
		result_digits   <= FIELD_W'(mag_c);
		overflow        <= ovf_c;
	end

endmodule
